// ----- hdl/dgcc_pkg.sv -----
package dgcc_pkg;

  typedef logic [4:0] vc_t;

  localparam int unsigned AddrW = 3;
  localparam int unsigned DataW = 32;

  // register index, taken from paddr[2]
  localparam logic RegVertexCount = 1'b0;
  localparam vc_t  VertexCountReset = 5'd16;

  localparam logic CmdAddEdge = 1'b0;
  localparam logic CmdCheck   = 1'b1;

  localparam logic StatOk     = 1'b0;
  localparam logic StatReject = 1'b1;

endpackage

// ----- hdl/dgcc_cfg.sv -----
module dgcc_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dgcc_pkg::AddrW-1:0] paddr,
  input  logic [dgcc_pkg::DataW-1:0] pwdata,
  output logic [dgcc_pkg::DataW-1:0] prdata,
  output logic                      pready,
  output dgcc_pkg::vc_t             vertex_count_o
);
  import dgcc_pkg::*;

  vc_t  vc_q;
  logic hit;

  assign hit    = (paddr[2] == RegVertexCount);
  assign pready = 1'b1;
  assign prdata = hit ? DataW'(vc_q) : '0;
  assign vertex_count_o = vc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= VertexCountReset;
    end else if (psel && penable && pwrite && pready && hit) begin
      vc_q <= pwdata[4:0];
    end
  end

endmodule

// ----- hdl/directed_graph_cycle_check_unit.sv -----
// Directed graph cycle checker.
// Commands enter on start with command_i, src_vertex_i and dst_vertex_i and are
// taken at an edge where start is high and busy is low. Each command gives one
// result on status_o and cyclic_o, valid for the single cycle in which done_o
// is high; the receiver cannot stall it, so results are simply dropped if not
// captured. A new command may be given in the cycle done_o is high.
// Add edge: an out-of-range edge is rejected straight from idle; otherwise the
// adjacency row is read, then the new bit is or-ed in and the row written back.
// Check: a depth-first search over the adjacency memory. Each neighbor bit is
// scanned at one per cycle, each push and pop costs a memory read of the next
// row (plus a stack memory read on pop), and each root is tried in turn; a
// found cycle ends the check early. The single-ported adjacency read and the
// bit-serial cursor set how long a check takes.
// vertex_count is written over the APB port; the user must write it only while
// the block is idle, as the block itself does not enforce this. Reset clears
// the graph at once through one valid flag per adjacency row, sets
// vertex_count to 16 and leaves the block idle.
module directed_graph_cycle_check_unit #(
  parameter int MAX_VERTICES = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic                      command_i,
  input  logic [3:0]                src_vertex_i,
  input  logic [3:0]                dst_vertex_i,
  output logic                      done_o,
  output logic                      status_o,
  output logic                      cyclic_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [dgcc_pkg::AddrW-1:0] paddr,
  input  logic [dgcc_pkg::DataW-1:0] pwdata,
  output logic [dgcc_pkg::DataW-1:0] prdata,
  output logic                      pready
);
  import dgcc_pkg::*;

  localparam int MaxV = MAX_VERTICES;
  localparam int IW   = $clog2(MAX_VERTICES);
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int SW   = IW + CW;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StAddWr = 3'd1;
  localparam logic [2:0] StRoot  = 3'd2;
  localparam logic [2:0] StLoad  = 3'd3;
  localparam logic [2:0] StScan  = 3'd4;
  localparam logic [2:0] StPopRd = 3'd5;

  vc_t vertex_count;

  dgcc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .vertex_count_o (vertex_count)
  );

  // memories
  logic [MaxV-1:0] adj_mem [MaxV];
  logic [SW-1:0]   stk_mem [MaxV];

  logic            adj_re, adj_we;
  logic [IW-1:0]   adj_ra, adj_wa;
  logic [MaxV-1:0] adj_wd, adj_rd_q;
  logic            stk_re, stk_we;
  logic [IW-1:0]   stk_ra, stk_wa;
  logic [SW-1:0]   stk_wd, stk_rd_q;

  always_ff @(posedge clk_i) begin
    if (adj_we) begin
      adj_mem[adj_wa] <= adj_wd;
    end
    if (adj_re) begin
      adj_rd_q <= adj_mem[adj_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  // control state
  logic [2:0]      state_q, state_d;
  logic            done_q, done_d;
  logic            status_q, status_d;
  logic            cyclic_q, cyclic_d;
  logic [CW-1:0]   depth_q, depth_d;
  logic [CW-1:0]   root_q, root_d;
  logic [MaxV-1:0] visited_q, visited_d;
  logic [MaxV-1:0] onpath_q, onpath_d;
  logic [MaxV-1:0] rowv_q, rowv_d;

  // datapath
  logic [IW-1:0]   cur_v_q, cur_v_d;
  logic [CW-1:0]   cur_w_q, cur_w_d;
  logic [MaxV-1:0] row_q, row_d;
  logic [IW-1:0]   src_q, src_d;
  logic [IW-1:0]   dst_q, dst_d;

  logic [CW-1:0]   act_n;
  logic [MaxV-1:0] vmask;
  logic            edge_bad;
  logic [IW-1:0]   w_idx;
  logic [IW-1:0]   root_idx;
  logic [MaxV-1:0] row_rd;

  always_comb begin
    act_n = (int'(vertex_count) > MaxV) ? CW'(MaxV) : CW'(vertex_count);
    for (int i = 0; i < MaxV; i++) begin
      vmask[i] = (i < int'(act_n));
    end
  end

  assign edge_bad = (int'(src_vertex_i) >= int'(act_n)) ||
                    (int'(dst_vertex_i) >= int'(act_n));
  assign w_idx    = cur_w_q[IW-1:0];
  assign root_idx = root_q[IW-1:0];

  // rows never written since reset read as empty
  assign row_rd = rowv_q[cur_v_q] ? adj_rd_q : '0;

  assign busy     = (state_q != StIdle);
  assign done_o   = done_q;
  assign status_o = status_q;
  assign cyclic_o = cyclic_q;

  // accesses are strictly sequenced: a row or stack entry is never written
  // and read in overlapping cycles, so no forwarding is needed
  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    status_d  = status_q;
    cyclic_d  = cyclic_q;
    depth_d   = depth_q;
    root_d    = root_q;
    visited_d = visited_q;
    onpath_d  = onpath_q;
    rowv_d    = rowv_q;
    cur_v_d   = cur_v_q;
    cur_w_d   = cur_w_q;
    row_d     = row_q;
    src_d     = src_q;
    dst_d     = dst_q;
    adj_re    = 1'b0;
    adj_ra    = cur_v_q;
    adj_we    = 1'b0;
    adj_wa    = src_q;
    adj_wd    = (rowv_q[src_q] ? adj_rd_q : '0) | ({{(MaxV-1){1'b0}}, 1'b1} << dst_q);
    stk_re    = 1'b0;
    stk_ra    = IW'(depth_q - CW'(2));
    stk_we    = 1'b0;
    stk_wa    = IW'(depth_q - CW'(1));
    stk_wd    = {cur_v_q, cur_w_q + CW'(1)};

    unique case (state_q)
      StIdle: begin
        if (start) begin
          if (command_i == CmdCheck) begin
            visited_d = '0;
            onpath_d  = '0;
            root_d    = '0;
            depth_d   = '0;
            state_d   = StRoot;
          end else if (edge_bad) begin
            done_d   = 1'b1;
            status_d = StatReject;
            cyclic_d = 1'b0;
          end else begin
            adj_re  = 1'b1;
            adj_ra  = IW'(src_vertex_i);
            src_d   = IW'(src_vertex_i);
            dst_d   = IW'(dst_vertex_i);
            state_d = StAddWr;
          end
        end
      end
      StAddWr: begin
        adj_we         = 1'b1;
        rowv_d[src_q]  = 1'b1;
        done_d         = 1'b1;
        status_d       = StatOk;
        cyclic_d       = 1'b0;
        state_d        = StIdle;
      end
      StRoot: begin
        if (root_q >= act_n) begin
          done_d   = 1'b1;
          status_d = StatOk;
          cyclic_d = 1'b0;
          state_d  = StIdle;
        end else if (visited_q[root_idx]) begin
          root_d = root_q + CW'(1);
        end else begin
          cur_v_d             = root_idx;
          cur_w_d             = '0;
          depth_d             = CW'(1);
          visited_d[root_idx] = 1'b1;
          onpath_d[root_idx]  = 1'b1;
          adj_re              = 1'b1;
          adj_ra              = root_idx;
          state_d             = StLoad;
        end
      end
      StLoad: begin
        row_d   = row_rd & vmask;
        state_d = StScan;
      end
      StScan: begin
        if (cur_w_q >= act_n) begin
          // all neighbors done: pop
          onpath_d[cur_v_q] = 1'b0;
          depth_d           = depth_q - CW'(1);
          if (depth_q == CW'(1)) begin
            state_d = StRoot;
          end else begin
            stk_re  = 1'b1;
            state_d = StPopRd;
          end
        end else if (row_q[w_idx]) begin
          if (onpath_q[w_idx]) begin
            // back edge closes a cycle
            depth_d  = '0;
            done_d   = 1'b1;
            status_d = StatOk;
            cyclic_d = 1'b1;
            state_d  = StIdle;
          end else if (!visited_q[w_idx]) begin
            stk_we           = 1'b1;
            cur_v_d          = w_idx;
            cur_w_d          = '0;
            depth_d          = depth_q + CW'(1);
            visited_d[w_idx] = 1'b1;
            onpath_d[w_idx]  = 1'b1;
            adj_re           = 1'b1;
            adj_ra           = w_idx;
            state_d          = StLoad;
          end else begin
            cur_w_d = cur_w_q + CW'(1);
          end
        end else begin
          cur_w_d = cur_w_q + CW'(1);
        end
      end
      StPopRd: begin
        cur_v_d = stk_rd_q[SW-1:CW];
        cur_w_d = stk_rd_q[CW-1:0];
        adj_re  = 1'b1;
        adj_ra  = stk_rd_q[SW-1:CW];
        state_d = StLoad;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      done_q    <= 1'b0;
      status_q  <= StatOk;
      cyclic_q  <= 1'b0;
      depth_q   <= '0;
      root_q    <= '0;
      visited_q <= '0;
      onpath_q  <= '0;
      rowv_q    <= '0;
    end else begin
      state_q   <= state_d;
      done_q    <= done_d;
      status_q  <= status_d;
      cyclic_q  <= cyclic_d;
      depth_q   <= depth_d;
      root_q    <= root_d;
      visited_q <= visited_d;
      onpath_q  <= onpath_d;
      rowv_q    <= rowv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_v_q <= cur_v_d;
    cur_w_q <= cur_w_d;
    row_q   <= row_d;
    src_q   <= src_d;
    dst_q   <= dst_d;
  end

endmodule
